// ===== sv/tacc_pkg.sv =====
`default_nettype none
package tacc_pkg;

   localparam int CORDIC_STAGES   = 16;
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int ACC_FRAC        = 24;
   localparam int TABLE_LEN       = 24;
   localparam int STG_W           = $clog2(TABLE_LEN);

   localparam int COORD_W   = 10;
   localparam int CFG_W     = 12;
   localparam int CSR_IDX_W = 2;
   localparam int DELTA_W   = 13;
   localparam int SCALE_LIM = 999;
   localparam int HYP_FRAC  = 16;

   // cordic datapath
   localparam int CW = 32;
   localparam int AW = 34;

   // square root: radicand is (dx^2 + dz^2) with 2*HYP_FRAC zero bits appended
   localparam int SQ_W     = 25;
   localparam int SQ_STEPS = 29;
   localparam int SQ_RAD_W = 2 * SQ_STEPS;
   localparam int SQ_REM_W = SQ_STEPS + 4;

   // pipeline depth in valid bits: delta, square, sum, sqrt cells, prerotate, cordic cells
   localparam int DEPTH = 3 + SQ_STEPS + 1 + CORDIC_STAGES;

   // output rounding
   localparam int OUT_W  = 16;
   localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int RND_W  = AW - RND_SH + 2;

   localparam logic signed [AW-1:0] NINETY_ACC = AW'(longint'(90) <<< ACC_FRAC);
   localparam logic signed [AW-1:0] RND_HALF   = AW'(longint'(1) <<< (RND_SH - 1));
   localparam logic signed [RND_W-1:0] NINETY_O = RND_W'(longint'(90) <<< ANGLE_FRAC_BITS);
   localparam logic signed [RND_W-1:0] ONE80_O  = RND_W'(longint'(180) <<< ANGLE_FRAC_BITS);
   localparam logic signed [RND_W-1:0] D360_O   = RND_W'(longint'(360) <<< ANGLE_FRAC_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_X = 2'd0,
      CSR_BASE_Y = 2'd1,
      CSR_BASE_Z = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] acc;
   } cordic_type;

   typedef struct packed {
      logic [SQ_RAD_W-1:0] rad;
      logic [SQ_REM_W-1:0] rem;
      logic [SQ_STEPS-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic signed [DELTA_W-1:0] dz;
   } delta_type;

   typedef struct packed {
      logic [OUT_W-1:0] swivel;
      logic [OUT_W-1:0] elbow;
      logic [OUT_W-1:0] elevation;
   } angles_type;

   // atan(2^-i) in degrees, ACC_FRAC fraction bits
   function automatic logic signed [AW-1:0] atan_deg(input logic [STG_W-1:0] idx);
      case (idx)
         5'd0:    return AW'(64'sd754974720);
         5'd1:    return AW'(64'sd445687602);
         5'd2:    return AW'(64'sd235489089);
         5'd3:    return AW'(64'sd119537938);
         5'd4:    return AW'(64'sd60000934);
         5'd5:    return AW'(64'sd30029717);
         5'd6:    return AW'(64'sd15018523);
         5'd7:    return AW'(64'sd7509720);
         5'd8:    return AW'(64'sd3754917);
         5'd9:    return AW'(64'sd1877466);
         5'd10:   return AW'(64'sd938734);
         5'd11:   return AW'(64'sd469367);
         5'd12:   return AW'(64'sd234684);
         5'd13:   return AW'(64'sd117342);
         5'd14:   return AW'(64'sd58671);
         5'd15:   return AW'(64'sd29335);
         5'd16:   return AW'(64'sd14668);
         5'd17:   return AW'(64'sd7334);
         5'd18:   return AW'(64'sd3667);
         5'd19:   return AW'(64'sd1833);
         5'd20:   return AW'(64'sd917);
         5'd21:   return AW'(64'sd458);
         5'd22:   return AW'(64'sd229);
         5'd23:   return AW'(64'sd115);
         default: return '0;
      endcase
   endfunction

   // bring the vector into the right half plane
   function automatic cordic_type prerotate(input logic signed [CW-1:0] y,
                                            input logic signed [CW-1:0] x);
      cordic_type r;
      r.x   = x;
      r.y   = y;
      r.acc = '0;
      if (x < 0) begin
         if (y >= 0) begin
            r.x   = y;
            r.y   = -x;
            r.acc = NINETY_ACC;
         end else begin
            r.x   = -y;
            r.y   = x;
            r.acc = -NINETY_ACC;
         end
      end
      return r;
   endfunction

   // round half up to the output fraction
   function automatic logic signed [RND_W-1:0] round_out(input logic signed [AW-1:0] a);
      logic signed [AW-1:0] t;
      t = a + RND_HALF;
      return RND_W'(t >>> RND_SH);
   endfunction

endpackage
`default_nettype wire

// ===== sv/tacc_sqrt_cell.sv =====
`default_nettype none
module tacc_sqrt_cell
   import tacc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     en,
   input  wire sqrt_type feed,
   output sqrt_type      result
);

   sqrt_type            stage_ff;
   sqrt_type            stage_in;
   logic [SQ_REM_W-1:0] rem_sh;
   logic [SQ_REM_W-1:0] trial;
   logic                fits;

   // one result bit per cell
   always_comb begin
      rem_sh         = {feed.rem[SQ_REM_W-3:0], feed.rad[SQ_RAD_W-1 -: 2]};
      trial          = {(SQ_REM_W-2)'(feed.root), 2'b01};
      fits           = (rem_sh >= trial);
      stage_in.rad   = feed.rad << 2;
      stage_in.rem   = fits ? (rem_sh - trial) : rem_sh;
      stage_in.root  = {feed.root[SQ_STEPS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign result = stage_ff;

endmodule
`default_nettype wire

// ===== sv/tacc_cordic_cell.sv =====
`default_nettype none
module tacc_cordic_cell
   import tacc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [STG_W-1:0] stage_idx,
   input  wire cordic_type       feed,
   output cordic_type            result
);

   cordic_type           stage_ff;
   cordic_type           stage_in;
   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;
   logic signed [AW-1:0] ang;

   // vectoring step, drives y toward zero
   always_comb begin
      xs  = feed.x >>> stage_idx;
      ys  = feed.y >>> stage_idx;
      ang = atan_deg(stage_idx);
      if (!feed.y[CW-1]) begin
         stage_in.x   = feed.x + ys;
         stage_in.y   = feed.y - xs;
         stage_in.acc = feed.acc + ang;
      end else begin
         stage_in.x   = feed.x - ys;
         stage_in.y   = feed.y + xs;
         stage_in.acc = feed.acc - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign result = stage_ff;

endmodule
`default_nettype wire

// ===== sv/target_aim_angle_calculator.sv =====
// a request passes delta, square, sum, sqrt, prerotate, cordic, output stages
// throughput: one request per cycle when not stalled; the 29-cell square root
//    chain and 16-cell cordic chains are fully pipelined, one cell per clock
// a skid entry behind the output register keeps the chain moving while a result
//    is stalled; the chain and req_stall hold once a second result is waiting
// reset clears the base position registers and every valid bit
`default_nettype none
module target_aim_angle_calculator
   import tacc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [COORD_W-1:0]   req_coord_x,
   input  wire logic [COORD_W-1:0]   req_coord_y,
   input  wire logic [COORD_W-1:0]   req_coord_z,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [OUT_W-1:0]          rsp_swivel_deg_q8,
   output logic [OUT_W-1:0]          rsp_elbow_deg_q8,
   output logic signed [OUT_W-1:0]   rsp_elevation_deg_q8
);

   // ---------------- configuration ----------------
   logic signed [CFG_W-1:0] base_x_ff, base_y_ff, base_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff <= '0;
         base_y_ff <= '0;
         base_z_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BASE_X: base_x_ff <= csr_wdata;
            CSR_BASE_Y: base_y_ff <= csr_wdata;
            CSR_BASE_Z: base_z_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   // the whole chain moves while the skid entry is free
   logic             en;
   logic [DEPTH-1:0] valid_ff;
   logic             skid_valid_ff;
   logic             out_valid_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_valid};
      end
   end

   // ---------------- scale and subtract base ----------------
   // floor(v*1000/999) is v, plus one once v reaches 999
   function automatic logic signed [DELTA_W-1:0] delta(input logic [COORD_W-1:0] v,
                                                      input logic signed [CFG_W-1:0] b);
      logic [COORD_W:0] cm;
      cm = {1'b0, v} + (COORD_W+1)'(v >= COORD_W'(SCALE_LIM));
      return $signed(DELTA_W'(cm)) - DELTA_W'(b);
   endfunction

   delta_type d0_ff, d1_ff, d2_ff;
   logic [SQ_W-2:0] dx2_ff, dz2_ff;
   logic [SQ_W-1:0] sq_ff;
   logic signed [2*DELTA_W-1:0] dx_prod, dz_prod;

   assign dx_prod = d0_ff.dx * d0_ff.dx;
   assign dz_prod = d0_ff.dz * d0_ff.dz;

   always_ff @(posedge clock) begin
      if (en) begin
         d0_ff.dx <= delta(req_coord_x, base_x_ff);
         d0_ff.dy <= delta(req_coord_y, base_y_ff);
         d0_ff.dz <= delta(req_coord_z, base_z_ff);
         // squares
         d1_ff    <= d0_ff;
         dx2_ff   <= dx_prod[SQ_W-2:0];
         dz2_ff   <= dz_prod[SQ_W-2:0];
         // sum of squares
         d2_ff    <= d1_ff;
         sq_ff    <= SQ_W'(dx2_ff) + SQ_W'(dz2_ff);
      end
   end

   // ---------------- square root chain ----------------
   sqrt_type  sq_link [SQ_STEPS+1];
   delta_type side_ff [SQ_STEPS];

   assign sq_link[0].rad  = SQ_RAD_W'({sq_ff, (2*HYP_FRAC)'(0)});
   assign sq_link[0].rem  = '0;
   assign sq_link[0].root = '0;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      tacc_sqrt_cell u_cell (
         .clock  (clock),
         .en     (en),
         .feed   (sq_link[k]),
         .result (sq_link[k+1])
      );
   end

   // deltas ride alongside the square root
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= d2_ff;
         for (int k = 1; k < SQ_STEPS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ---------------- prerotation ----------------
   logic signed [CW-1:0] sx, sy, ex, ey;
   cordic_type           swv_link [CORDIC_STAGES+1];
   cordic_type           elv_link [CORDIC_STAGES+1];
   logic                 swv_zero_ff [CORDIC_STAGES+1];
   logic                 elv_zero_ff [CORDIC_STAGES+1];

   assign sx = CW'(side_ff[SQ_STEPS-1].dx) <<< HYP_FRAC;
   assign sy = CW'(side_ff[SQ_STEPS-1].dz) <<< HYP_FRAC;
   assign ex = $signed(CW'(sq_link[SQ_STEPS].root));
   assign ey = CW'(side_ff[SQ_STEPS-1].dy) <<< HYP_FRAC;

   cordic_type swv_pre_ff, elv_pre_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         swv_pre_ff     <= prerotate(sy, sx);
         elv_pre_ff     <= prerotate(ey, ex);
         // atan2 of the zero vector is zero
         swv_zero_ff[0] <= (sx == '0) && (sy == '0);
         elv_zero_ff[0] <= (ex == '0) && (ey == '0);
         for (int k = 1; k <= CORDIC_STAGES; k++) begin
            swv_zero_ff[k] <= swv_zero_ff[k-1];
            elv_zero_ff[k] <= elv_zero_ff[k-1];
         end
      end
   end

   assign swv_link[0] = swv_pre_ff;
   assign elv_link[0] = elv_pre_ff;

   // ---------------- cordic chains ----------------
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      tacc_cordic_cell u_swv (
         .clock     (clock),
         .en        (en),
         .stage_idx (STG_W'(i)),
         .feed      (swv_link[i]),
         .result    (swv_link[i+1])
      );
      tacc_cordic_cell u_elv (
         .clock     (clock),
         .en        (en),
         .stage_idx (STG_W'(i)),
         .feed      (elv_link[i]),
         .result    (elv_link[i+1])
      );
   end

   // ---------------- offsets and clamps ----------------
   logic signed [RND_W-1:0] swv_r, elv_r, swv_o, elb_o;
   angles_type              fin;

   always_comb begin
      swv_r = swv_zero_ff[CORDIC_STAGES] ? '0 : round_out(swv_link[CORDIC_STAGES].acc);
      elv_r = elv_zero_ff[CORDIC_STAGES] ? '0 : round_out(elv_link[CORDIC_STAGES].acc);
      // swivel behind the base wraps, then clamps to the top of range
      swv_o = swv_r + NINETY_O;
      if (swv_o < 0) begin
         swv_o = swv_o + D360_O;
      end
      if (swv_o > ONE80_O) begin
         swv_o = ONE80_O;
      end
      if (swv_o < 0) begin
         swv_o = '0;
      end
      elb_o = NINETY_O - elv_r;
      if (elb_o < 0) begin
         elb_o = '0;
      end
      if (elb_o > ONE80_O) begin
         elb_o = ONE80_O;
      end
      fin.swivel    = swv_o[OUT_W-1:0];
      fin.elbow     = elb_o[OUT_W-1:0];
      fin.elevation = elv_r[OUT_W-1:0];
   end

   // ---------------- output register and skid ----------------
   angles_type out_ff, skid_ff;
   logic       last_valid;

   assign last_valid = valid_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         if (out_valid_ff && rsp_stall) begin
            skid_valid_ff <= last_valid;
         end else begin
            out_valid_ff  <= last_valid;
         end
      end else if (!rsp_stall) begin
         // skid drains into the output register
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (out_valid_ff && rsp_stall) begin
            skid_ff <= fin;
         end else begin
            out_ff  <= fin;
         end
      end else if (!rsp_stall) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_swivel_deg_q8    = out_ff.swivel;
   assign rsp_elbow_deg_q8     = out_ff.elbow;
   assign rsp_elevation_deg_q8 = out_ff.elevation;

`ifndef SYNTH
   // a parked result always sits behind a shown one
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output result");

   // a parked result stays parked while the consumer stalls
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("skid entry lost under stall");

   // a result leaving the chain into an empty output is shown next cycle
   a_last_shown: assert property (@(posedge clock) disable iff (reset)
      en && last_valid && !out_valid_ff |=> out_valid_ff)
      else $error("result from the chain dropped");
`endif

endmodule
`default_nettype wire
